// ===== sv/tsl_pkg.sv =====
`timescale 1ns / 1ps
// tsl_pkg: shared types and constants for the triangle strip to list unit
// no dependencies

package tsl_pkg;

  // width of a corner on the result side
  localparam int CORNER_BITS = 31;
  // index words added by one triangle
  localparam logic [31:0] TRI_WORDS = 32'd3;

  // input item
  typedef struct packed {
    logic signed [31:0] index_value;
    logic               strip_start;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [CORNER_BITS-1:0] corner_first;
    logic [CORNER_BITS-1:0] corner_second;
    logic [CORNER_BITS-1:0] corner_third;
    logic                   capacity_exceeded;
    logic [31:0]            indices_written;
  } out_item_t;

  // command kinds passed from front to back
  typedef enum logic {
    OP_TRIANGLE,
    OP_OVERFLOW
  } tsl_op_t;

  // command queued between front and back
  typedef struct packed {
    tsl_op_t                op;
    logic                   flip;
    logic [CORNER_BITS-1:0] older;
    logic [CORNER_BITS-1:0] newer;
    logic [CORNER_BITS-1:0] current;
    logic [31:0]            count;
  } tsl_cmd_t;

endpackage

// ===== sv/tsl_front.sv =====
`timescale 1ns / 1ps
// tsl_front: takes index items, tracks held corners, winding and count,
// and queues triangle or overflow commands; depends on tsl_pkg

module tsl_front #(
  parameter int INDEX_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tsl_pkg::in_item_t in_item,
  input  logic              full,
  input  logic              capacity_write,
  input  logic [31:0]       capacity_data,
  output logic              cmd_push,
  output tsl_pkg::tsl_cmd_t cmd
);
  import tsl_pkg::*;

  localparam int HELD_BITS = INDEX_BITS - 1;

  logic [31:0]          capacity;
  logic [HELD_BITS-1:0] older, older_next;
  logic [HELD_BITS-1:0] newer, newer_next;
  logic                 older_valid, older_valid_next;
  logic                 newer_valid, newer_valid_next;
  logic                 winding, winding_next;
  logic [31:0]          written_count, written_count_next;
  logic                 halted, halted_next;

  logic                  accept;
  logic [INDEX_BITS-1:0] idx;
  logic                  negative;
  logic [HELD_BITS-1:0]  k;
  logic                  older_valid_eff;
  logic                  newer_valid_eff;
  logic                  winding_eff;
  logic [32:0]           sum;
  logic                  overflow;

  assign accept   = push && !full;
  assign idx      = in_item.index_value[INDEX_BITS-1:0];
  assign negative = idx[INDEX_BITS-1];
  assign k        = idx[HELD_BITS-1:0];

  // a new strip record clears the held corners before the index is handled
  assign older_valid_eff = older_valid && !in_item.strip_start;
  assign newer_valid_eff = newer_valid && !in_item.strip_start;
  assign winding_eff     = winding || in_item.strip_start;

  // capacity check on the widened count
  assign sum      = {1'b0, written_count} + {1'b0, TRI_WORDS};
  assign overflow = sum > {1'b0, capacity};

  // next state and command
  always_comb begin
    older_next         = older;
    newer_next         = newer;
    older_valid_next   = older_valid;
    newer_valid_next   = newer_valid;
    winding_next       = winding;
    written_count_next = written_count;
    halted_next        = halted;
    cmd_push           = 1'b0;
    cmd.op             = OP_TRIANGLE;
    cmd.flip           = ~winding_eff;
    cmd.older          = CORNER_BITS'(older);
    cmd.newer          = CORNER_BITS'(newer);
    cmd.current        = CORNER_BITS'(k);
    cmd.count          = sum[31:0];
    if (accept && !halted) begin
      if (negative) begin
        older_valid_next = 1'b0;
        newer_valid_next = 1'b0;
        winding_next     = 1'b1;
      end else if (!older_valid_eff) begin
        older_next       = k;
        older_valid_next = 1'b1;
        newer_valid_next = 1'b0;
        winding_next     = winding_eff;
      end else if (!newer_valid_eff) begin
        newer_next       = k;
        newer_valid_next = 1'b1;
        winding_next     = winding_eff;
      end else if (overflow) begin
        halted_next = 1'b1;
        cmd_push    = 1'b1;
        cmd.op      = OP_OVERFLOW;
        cmd.count   = written_count;
      end else begin
        written_count_next = sum[31:0];
        winding_next       = ~winding_eff;
        older_next         = newer;
        newer_next         = k;
        cmd_push           = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= 32'hFFFF_FFFF;
      older_valid   <= 1'b0;
      newer_valid   <= 1'b0;
      winding       <= 1'b1;
      written_count <= '0;
      halted        <= 1'b0;
    end else begin
      if (capacity_write) begin
        capacity <= capacity_data;
      end
      older_valid   <= older_valid_next;
      newer_valid   <= newer_valid_next;
      winding       <= winding_next;
      written_count <= written_count_next;
      halted        <= halted_next;
    end
  end

  // held corners
  always_ff @(posedge clk) begin
    older <= older_next;
    newer <= newer_next;
  end

`ifndef NO_ASSERTIONS
  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt flag cleared without reset");

  a_no_cmd_halted: assert property (@(posedge clk) disable iff (rst)
    halted |-> !cmd_push)
    else $error("command issued while halted");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (cmd_push && cmd.op == OP_TRIANGLE) |=>
      written_count == $past(written_count) + TRI_WORDS)
    else $error("count did not advance by one triangle");

  a_newer_needs_older: assert property (@(posedge clk) disable iff (rst)
    newer_valid |-> older_valid)
    else $error("newer corner held without older corner");
`endif

endmodule

// ===== sv/tsl_queue.sv =====
`timescale 1ns / 1ps
// tsl_queue: short command queue between front and back
// depends on tsl_pkg

module tsl_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tsl_pkg::tsl_cmd_t cmd_in,
  output logic              full,
  input  logic              pop,
  output logic              nonempty,
  output tsl_pkg::tsl_cmd_t cmd_out
);
  import tsl_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  tsl_cmd_t            mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full     = count == CNT_BITS'(DEPTH);
  assign nonempty = count != '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign cmd_out  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= cmd_in;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(DEPTH))
    else $error("queue fill count out of range");
`endif

endmodule

// ===== sv/tsl_back.sv =====
`timescale 1ns / 1ps
// tsl_back: turns queued commands into result items in an output register
// depends on tsl_pkg

module tsl_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  tsl_pkg::tsl_cmd_t  cmd,
  output logic               cmd_pop,
  output logic               empty,
  input  logic               pop,
  output tsl_pkg::out_item_t out_item
);
  import tsl_pkg::*;

  logic      out_valid;
  out_item_t result;

  // load when the register is free or being taken this cycle
  assign cmd_pop = cmd_valid && (!out_valid || pop);
  assign empty   = !out_valid;

  // result formatting: winding picks the corner order; an overflow command zeroes the corners and sets the flag
  always_comb begin
    result.corner_third      = cmd.current;
    result.indices_written   = cmd.count;
    result.capacity_exceeded = 1'b0;
    if (cmd.flip) begin
      result.corner_first  = cmd.newer;
      result.corner_second = cmd.older;
    end else begin
      result.corner_first  = cmd.older;
      result.corner_second = cmd.newer;
    end
    case (cmd.op)
      OP_OVERFLOW: begin
        result.corner_first      = '0;
        result.corner_second     = '0;
        result.corner_third      = '0;
        result.capacity_exceeded = 1'b1;
      end
      default: begin
        result.capacity_exceeded = 1'b0;
      end
    endcase
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      out_item <= result;
    end
  end

endmodule

// ===== sv/triangle_strip_to_list_unit.sv =====
`timescale 1ns / 1ps
// triangle_strip_to_list_unit: top level of the strip to list assembler
// depends on tsl_pkg, tsl_front, tsl_queue, tsl_back
//
// Usage:
//   Input queue side: an item (vertex index, strip start flag) is taken at
//   an edge with push high and full low. A negative index at INDEX_BITS
//   width restarts the strip; the first two indices of a strip are held,
//   each later one yields one triangle with alternating winding.
//   Result queue side: while empty is low the oldest triangle sits on
//   out_item; pop high at an edge takes it.
//   Capacity: capacity_write loads capacity_data at the edge; write only
//   while idle. A triangle that would pass the capacity gives one flagged
//   item instead and the unit then drops every later index until reset.
//   Throughput: one item per cycle while full is low. A result passes
//   through the command queue and then the output register.
//   Stall: while pop is low, results wait in the QUEUE_DEPTH command queue
//   plus the output register; full rises when the queue is full.
//   Reset: rst clears corners, count, halt flag and queues; capacity
//   returns to all ones. No clearing pass is needed.

module triangle_strip_to_list_unit #(
  parameter int INDEX_BITS  = 32,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  tsl_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output tsl_pkg::out_item_t out_item,
  input  logic               capacity_write,
  input  logic [31:0]        capacity_data
);
  import tsl_pkg::*;

  logic     cmd_push;
  tsl_cmd_t cmd_in;
  logic     q_nonempty;
  logic     q_pop;
  tsl_cmd_t cmd_out;

  // front: classify and track strip state
  tsl_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .in_item        (in_item),
    .full           (full),
    .capacity_write (capacity_write),
    .capacity_data  (capacity_data),
    .cmd_push       (cmd_push),
    .cmd            (cmd_in)
  );

  // command queue
  tsl_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .cmd_in   (cmd_in),
    .full     (full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .cmd_out  (cmd_out)
  );

  // back: result formatting and output register
  tsl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_nonempty),
    .cmd       (cmd_out),
    .cmd_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

// ===== dv/triangle_strip_to_list_unit_test.sv =====
`timescale 1ns / 1ps
// triangle_strip_to_list_unit_test: self-checking bench for the strip to list unit
// depends on tsl_pkg and triangle_strip_to_list_unit

module triangle_strip_to_list_unit_test;
  import tsl_pkg::*;

  localparam int          INDEX_W     = 32;
  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [31:0] NO_CORNER   = 32'hFFFF_FFFF;
  localparam logic [31:0] CAP_MAX     = 32'hFFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item;
  logic        capacity_write = 1'b0;
  logic [31:0] capacity_data = '0;

  // predictor state
  logic [31:0] older_corner = NO_CORNER;
  logic [31:0] newer_corner = NO_CORNER;
  logic        wind_odd = 1'b1;
  logic [31:0] word_total = '0;
  logic        locked = 1'b0;
  logic [31:0] list_capacity = CAP_MAX;

  in_item_t  pending_indices[$];
  out_item_t expected_triangles[$];

  int   indices_accepted = 0;
  int   triangles_checked = 0;
  int   overflows_checked = 0;
  int   restarts_seen = 0;
  int   mismatches = 0;
  int   cycle_count = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic steady;

  triangle_strip_to_list_unit #(
    .INDEX_BITS(INDEX_W)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .in_item       (in_item),
    .empty         (empty),
    .pop           (pop),
    .out_item      (out_item),
    .capacity_write(capacity_write),
    .capacity_data (capacity_data)
  );

  // clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // no idling on either side over a middle stretch of the run
  assign steady = (indices_accepted >= 900) && (indices_accepted < 1300);

  // empty both corners and restore the winding
  function automatic void clear_corners();
    older_corner = NO_CORNER;
    newer_corner = NO_CORNER;
    wind_odd     = 1'b1;
  endfunction

  // work out the triangle, if any, that one accepted index gives
  function automatic void assemble_index(in_item_t item);
    out_item_t   triangle;
    logic [31:0] k;
    k = item.index_value;
    if (locked) return;
    if (item.strip_start) clear_corners();
    if (k[INDEX_W-1]) begin
      clear_corners();
      restarts_seen++;
      return;
    end
    if (older_corner == NO_CORNER) begin
      older_corner = k;
      return;
    end
    if (newer_corner == NO_CORNER) begin
      newer_corner = k;
      return;
    end
    triangle = '0;
    // triangle would not fit: flagged item, then nothing until reset
    if (({1'b0, word_total} + {1'b0, TRI_WORDS}) > {1'b0, list_capacity}) begin
      locked = 1'b1;
      triangle.capacity_exceeded = 1'b1;
      triangle.indices_written   = word_total;
      expected_triangles.insert(expected_triangles.size(), triangle);
      return;
    end
    word_total = word_total + TRI_WORDS;
    wind_odd   = ~wind_odd;
    if (wind_odd) begin
      triangle.corner_first  = newer_corner[CORNER_BITS-1:0];
      triangle.corner_second = older_corner[CORNER_BITS-1:0];
    end else begin
      triangle.corner_first  = older_corner[CORNER_BITS-1:0];
      triangle.corner_second = newer_corner[CORNER_BITS-1:0];
    end
    triangle.corner_third    = k[CORNER_BITS-1:0];
    triangle.indices_written = word_total;
    expected_triangles.insert(expected_triangles.size(), triangle);
    older_corner = newer_corner;
    newer_corner = k;
  endfunction

  // driver: offers pending items, holds an item while full is high
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        assemble_index(in_item);
        indices_accepted++;
      end
      if (!push || !full) begin
        if (pending_indices.size() != 0 && (steady || $urandom_range(0, 99) >= 26)) begin
          push    <= 1'b1;
          in_item <= pending_indices.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (expected !== actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      mismatches++;
    end
  endtask

  // one long hold-off so the unit fills and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && indices_accepted >= 300) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks each popped item against the oldest expected triangle
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_triangles.size() == 0) begin
          $error("result item with no triangle expected");
          mismatches++;
        end else begin
          want = expected_triangles.pop_front();
          check_field("corner_first", 32'(want.corner_first),
                      32'(out_item.corner_first));
          check_field("corner_second", 32'(want.corner_second),
                      32'(out_item.corner_second));
          check_field("corner_third", 32'(want.corner_third),
                      32'(out_item.corner_third));
          check_field("capacity_exceeded", 32'(want.capacity_exceeded),
                      32'(out_item.capacity_exceeded));
          check_field("indices_written", want.indices_written, out_item.indices_written);
          if (want.capacity_exceeded) overflows_checked++;
          else triangles_checked++;
        end
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_index(logic [31:0] value, logic start);
    in_item_t item;
    item.index_value = value;
    item.strip_start = start;
    pending_indices.insert(pending_indices.size(), item);
  endtask

  // random strips: mostly valid indices, some restarts and new records
  task automatic queue_random(int count);
    logic [31:0] value;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) value = {1'b1, 31'($urandom())};
      else if (pick < 35) value = $urandom_range(0, 255);
      else value = {1'b0, 31'($urandom())};
      queue_index(value, $urandom_range(0, 99) < 6);
    end
  endtask

  // wait until everything sent has been taken and answered
  task automatic settle();
    while (pending_indices.size() != 0 || push || expected_triangles.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic load_capacity(logic [31:0] value);
    @(posedge clk);
    capacity_write <= 1'b1;
    capacity_data  <= value;
    @(posedge clk);
    capacity_write <= 1'b0;
    list_capacity = value;
  endtask

  // stimulus sequence
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, winding, restarts, new strip records
    queue_index(32'h0000_0000, 1'b1);
    queue_index(32'h7FFF_FFFF, 1'b0);
    queue_index(32'h0000_0000, 1'b0);
    queue_index(32'd1, 1'b0);
    queue_index(32'd2, 1'b0);
    queue_index(32'hFFFF_FFFF, 1'b0);
    queue_index(32'h8000_0000, 1'b0);
    queue_index(32'd3, 1'b0);
    queue_index(32'd4, 1'b1);
    queue_index(32'd5, 1'b0);
    queue_index(32'd6, 1'b0);
    queue_index(-32'sd5, 1'b1);
    queue_index(32'h5555_5555, 1'b0);
    queue_index(32'h2AAA_AAAA, 1'b0);
    queue_index(32'h7FFF_FFFE, 1'b0);
    queue_index(32'h1234_5678, 1'b0);
    queue_index(32'd7, 1'b1);
    queue_index(32'd8, 1'b0);
    queue_index(32'h4000_0000, 1'b0);
    queue_index(32'h7FFF_FFFF, 1'b0);
    queue_index(32'hAAAA_AAAA, 1'b0);
    settle();

    load_capacity(CAP_MAX);
    queue_random(500);
    settle();

    // capacity reached exactly, without passing it
    load_capacity(word_total + 32'd12);
    for (int i = 0; i < 6; i++) queue_index(32'd100 + i, i == 0);
    settle();

    load_capacity(word_total + 32'd3000 + $urandom_range(0, 5));
    queue_random(1000);
    settle();

    // zero capacity: the next triangle overflows and the unit halts
    load_capacity(32'd0);
    queue_index(32'd9, 1'b1);
    queue_index(32'd10, 1'b0);
    queue_index(32'd11, 1'b0);
    queue_random(30);
    settle();

    // a capacity write after the halt must not wake the unit
    load_capacity(CAP_MAX);
    queue_random(20);
    settle();

    $display("%0d index items accepted, %0d strip restarts", indices_accepted, restarts_seen);
    $display("%0d triangles and %0d overflow items checked", triangles_checked,
             overflows_checked);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
